>>> hdl/msc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pkg
// Shared constants, types and the color lookup for the monochrome scan-out.
// ----------------------------------------------------------------------------
package msc_pkg;

   // Frame geometry and memory layout
   localparam int BYTES_PER_LINE = 90;
   localparam int VISIBLE_LINES  = 348;
   localparam int BANK_BYTES     = 8192;
   localparam int MEMORY_BYTES   = 32768;
   localparam int SCAN_BANKS     = 4;

   localparam int LINE_PIXELS = BYTES_PER_LINE * 8;
   localparam int ADDR_W      = $clog2(MEMORY_BYTES);
   localparam int COL_W       = 10;
   localparam int ROW_W       = 9;
   localparam int BANK_W      = $clog2(SCAN_BANKS);

   // Color scheme codes
   localparam logic [1:0] SCHEME_GREEN   = 2'd1;
   localparam logic [1:0] SCHEME_PALE    = 2'd2;
   localparam logic [1:0] SCHEME_INVERT  = 2'd3;
   localparam logic [1:0] SCHEME_RESET   = SCHEME_GREEN;

   // Request kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             last;
   } raster_pos_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Map one pixel bit to a color under the selected scheme
   function automatic rgb_type pick_color(input logic [1:0] scheme, input logic lit);
      rgb_type fg;
      rgb_type bg;
      case (scheme)
         SCHEME_PALE: begin
            fg = '{red: 8'd215, green: 8'd255, blue: 8'd215};
            bg = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
         end
         SCHEME_INVERT: begin
            fg = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
            bg = '{red: 8'd255, green: 8'd255, blue: 8'd255};
         end
         default: begin
            fg = '{red: 8'd64,  green: 8'd255, blue: 8'd64};
            bg = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
         end
      endcase
      return lit ? fg : bg;
   endfunction

endpackage

>>> hdl/msc_vram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_vram
// Video memory: one write port, one registered read port, and a clearing
// sweep after reset that zeroes every byte before requests are taken.
// ----------------------------------------------------------------------------
module msc_vram
   import msc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data,
   output logic              busy
);

   logic [7:0]        mem [MEMORY_BYTES];
   logic [7:0]        rd_data_ff;
   logic              clear_ff;
   logic              clear_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;

   // Step the clearing sweep one byte a cycle
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clear_in    = clear_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {ADDR_W{1'b1}}) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Select the sweep or the write request on the write port
   always_comb begin
      mem_we    = clear_ff | wr_en;
      mem_waddr = clear_ff ? clr_addr_ff : wr_addr;
      mem_wdata = clear_ff ? 8'd0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   // Hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clear_ff;

endmodule

>>> hdl/msc_raster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_raster
// Raster position counters and the interleaved read address of the
// current pixel's byte.
// ----------------------------------------------------------------------------
module msc_raster
   import msc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   output raster_pos_type    pos,
   output logic [ADDR_W-1:0] rd_addr
);

   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(LINE_PIXELS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(VISIBLE_LINES - 1);
   localparam logic [BANK_W-1:0] BANK_LAST = BANK_W'(SCAN_BANKS - 1);

   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;
   logic [ADDR_W-1:0] base_ff;   // (row / 4) * BYTES_PER_LINE
   logic [ADDR_W-1:0] base_in;
   logic              col_end;
   logic              row_end;

   assign col_end = (col_ff == COL_LAST);
   assign row_end = (row_ff == ROW_LAST);

   // Advance column, line and line base on each tick
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      base_in = base_ff;
      if (advance) begin
         if (col_end) begin
            col_in = '0;
            if (row_end) begin
               row_in  = '0;
               base_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
               if (row_ff[BANK_W-1:0] == BANK_LAST) begin
                  base_in = base_ff + ADDR_W'(BYTES_PER_LINE);
               end
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         base_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         base_ff <= base_in;
      end
   end

   // Bank select plus line base plus byte column, wrapped to memory size
   assign rd_addr = ADDR_W'(row_ff[BANK_W-1:0]) * ADDR_W'(BANK_BYTES)
                  + base_ff + ADDR_W'(col_ff[COL_W-1:3]);

   assign pos.column = col_ff;
   assign pos.row    = row_ff;
   assign pos.last   = col_end & row_end;

endmodule

>>> hdl/msc_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pixel
// Pixel stage behind the memory read and the response register with its
// stall control.
// ----------------------------------------------------------------------------
module msc_pixel
   import msc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             issue,
   input  raster_pos_type   pos,
   input  logic [7:0]       rd_data,
   input  logic [1:0]       scheme,
   output logic             can_issue,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [COL_W-1:0] rsp_column,
   output logic [ROW_W-1:0] rsp_row,
   output logic             rsp_frame_end
);

   logic           s1_valid_ff;
   logic           s1_valid_in;
   raster_pos_type s1_pos_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   raster_pos_type out_pos_ff;
   rgb_type        out_rgb_ff;
   rgb_type        rgb;
   logic           out_free;
   logic           move;
   logic           lit;

   assign out_free  = ~out_valid_ff | rsp_ready;
   assign move      = s1_valid_ff & out_free;
   assign can_issue = ~s1_valid_ff | out_free;

   // Pick the pixel bit, MSB leftmost
   assign lit = rd_data[3'd7 - s1_pos_ff.column[2:0]];
   assign rgb = pick_color(scheme, lit);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (issue) begin
         s1_valid_in = 1'b1;
      end else if (move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture position alongside the memory read
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_pos_ff <= pos;
      end
   end

   // Load the response register when the pixel stage moves on
   always_ff @(posedge clock) begin
      if (move) begin
         out_pos_ff <= s1_pos_ff;
         out_rgb_ff <= rgb;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_red       = out_rgb_ff.red;
   assign rsp_green     = out_rgb_ff.green;
   assign rsp_blue      = out_rgb_ff.blue;
   assign rsp_column    = out_pos_ff.column;
   assign rsp_row       = out_pos_ff.row;
   assign rsp_frame_end = out_pos_ff.last;

endmodule

>>> hdl/mono_graphics_scanout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_graphics_scanout
// Monochrome graphics scan-out from a four-bank interleaved video memory.
//
//   Channel  Direction  Handshake              Content
//   req_     in         req_valid / req_ready  kind, address, data
//   rsp_     out        rsp_valid / rsp_ready  red, green, blue, column, row,
//                                              frame_end
//   csr_     in         csr_write_enable       color scheme (2 bits)
//
// One request per clock; a tick's pixel passes the synchronous memory read
// and then the response register before it appears.
// After reset the memory is swept to zero, all 32768 bytes, one byte a
// cycle, with req_ready low; CSR writes are taken throughout.
// rsp_ready low holds the response; req_ready falls once the pixel stage
// behind the memory is also full.
// ----------------------------------------------------------------------------
module mono_graphics_scanout
   import msc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  logic [14:0]      req_address,
   input  logic [7:0]       req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [9:0]       rsp_column,
   output logic [8:0]       rsp_row,
   output logic             rsp_frame_end,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_write_data
);

   logic [1:0]        scheme_reg_ff;
   logic              busy;
   logic              can_issue;
   logic              accept;
   logic              tick;
   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   raster_pos_type    pos;

   // Hold the color scheme register
   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_reg_ff <= SCHEME_RESET;
      end else if (csr_write_enable) begin
         scheme_reg_ff <= csr_write_data;
      end
   end

   assign req_ready = ~busy & can_issue;
   assign accept    = req_valid & req_ready;
   assign tick      = accept & (req_kind == KIND_TICK);
   assign wr_en     = accept & (req_kind == KIND_WRITE);

   msc_vram u_vram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_address)),
      .wr_data (req_data),
      .rd_en   (tick),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .busy    (busy)
   );

   msc_raster u_raster (
      .clock   (clock),
      .reset   (reset),
      .advance (tick),
      .pos     (pos),
      .rd_addr (rd_addr)
   );

   msc_pixel u_pixel (
      .clock         (clock),
      .reset         (reset),
      .issue         (tick),
      .pos           (pos),
      .rd_data       (rd_data),
      .scheme        (scheme_reg_ff),
      .can_issue     (can_issue),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_column    (rsp_column),
      .rsp_row       (rsp_row),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the monochrome graphics scan-out.
//
// Requests (memory writes and pixel ticks) are queued by a stimulus process
// and offered by a clocked driver. The driver keeps a shadow of the video
// memory, the raster position and the color scheme, and predicts a pixel for
// every tick it hands over. A clocked monitor checks each pixel against the
// oldest prediction. Phases run under different color schemes, and the
// raster crosses at least one line end.
// ----------------------------------------------------------------------------
module tb;
   import msc_pkg::*;

   localparam int           IDLE_PCT         = 15;
   localparam int           STALL_LIMIT      = 100000;
   localparam int           SETTLE_CYCLES    = 8;
   localparam int           SHOW_LIMIT       = 30;
   localparam int           TAIL_TICKS       = 40;
   localparam logic [1:0]   SCHEME_GREEN_ALT = 2'd0;

   typedef struct packed {
      logic        kind;
      logic [14:0] address;
      logic [7:0]  data;
   } req_item_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [9:0] column;
      logic [8:0] row;
      logic       frame_end;
   } pixel_type;

   // DUT ports
   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic        req_kind         = KIND_WRITE;
   logic [14:0] req_address      = '0;
   logic [7:0]  req_data         = '0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [9:0]  rsp_column;
   logic [8:0]  rsp_row;
   logic        rsp_frame_end;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_write_data   = '0;

   // Request queue and pixel predictions
   req_item_type pending_reqs[$];
   pixel_type    expected_pixels[$];
   req_item_type on_wire;

   // Shadow of the block state
   logic [7:0]  shadow_vram[MEMORY_BYTES];
   logic [9:0]  beam_col;
   logic [8:0]  beam_line;
   logic [1:0]  scheme_sel = SCHEME_RESET;

   // Raster position as seen by the stimulus side
   int          gen_col  = 0;
   int          gen_line = 0;

   int          reqs_queued   = 0;
   int          reqs_taken    = 0;
   int          writes_taken  = 0;
   int          pixels_seen   = 0;
   int          frames_done   = 0;
   int          fault_count   = 0;
   int          shown_faults  = 0;
   int          scheme_writes = 0;
   int          hold_left     = 0;
   bit          hold_done     = 1'b0;
   int          stall_cycles  = 0;
   int          clr_i;

   mono_graphics_scanout uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_frame_end    (rsp_frame_end),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Byte address of column 0 of a source line
   function automatic int line_base(input int line);
      return (line % SCAN_BANKS) * BANK_BYTES + (line / SCAN_BANKS) * BYTES_PER_LINE;
   endfunction

   // Apply one accepted request to the shadow state; queue the pixel of a tick
   task automatic predict_request(input req_item_type r);
      pixel_type px;
      int        rd_addr;
      logic      lit;
      if (r.kind == KIND_WRITE) begin
         shadow_vram[r.address] = r.data;
         writes_taken++;
      end else begin
         rd_addr = (line_base(int'(beam_line)) + int'(beam_col) / 8) % MEMORY_BYTES;
         lit = shadow_vram[rd_addr][7 - int'(beam_col[2:0])];
         case (scheme_sel)
            SCHEME_PALE: begin
               {px.red, px.green, px.blue} = lit ? {8'd215, 8'd255, 8'd215} : 24'h000000;
            end
            SCHEME_INVERT: begin
               {px.red, px.green, px.blue} = lit ? 24'h000000 : 24'hFFFFFF;
            end
            default: begin
               {px.red, px.green, px.blue} = lit ? {8'd64, 8'd255, 8'd64} : 24'h000000;
            end
         endcase
         px.column    = beam_col;
         px.row       = beam_line;
         px.frame_end = (int'(beam_col) == LINE_PIXELS - 1) &&
                        (int'(beam_line) == VISIBLE_LINES - 1);
         expected_pixels.push_back(px);
         // advance the beam, wrapping at line and frame end
         if (int'(beam_col) == LINE_PIXELS - 1) begin
            beam_col = '0;
            beam_line = (int'(beam_line) == VISIBLE_LINES - 1) ? '0 : beam_line + 1'b1;
         end else begin
            beam_col = beam_col + 1'b1;
         end
      end
   endtask

   // Driver: offer queued requests, idling at random outside the calm window
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         for (clr_i = 0; clr_i < MEMORY_BYTES; clr_i++) shadow_vram[clr_i] = 8'h00;
         beam_col  = '0;
         beam_line = '0;
      end else begin
         if (req_valid && req_ready) begin
            predict_request(on_wire);
            reqs_taken++;
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0 &&
                ((reqs_taken >= 800 && reqs_taken < 1400) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
               on_wire      = pending_reqs.pop_front();
               req_valid   <= 1'b1;
               req_kind    <= on_wire.kind;
               req_address <= on_wire.address;
               req_data    <= on_wire.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_fault(input string what, input pixel_type want,
                               input pixel_type got);
      fault_count++;
      if (shown_faults < SHOW_LIMIT) begin
         shown_faults++;
         $display("%0t ns %s: expected rgb=%0d/%0d/%0d col=%0d row=%0d end=%0b,",
                  $time, what, want.red, want.green, want.blue, want.column,
                  want.row, want.frame_end);
         $display("   got rgb=%0d/%0d/%0d col=%0d row=%0d end=%0b",
                  got.red, got.green, got.blue, got.column, got.row, got.frame_end);
      end
   endtask

   // Monitor: check pixels, stall at random, and hold off once for a long stretch
   always @(posedge clock) begin
      pixel_type got;
      pixel_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{red: rsp_red, green: rsp_green, blue: rsp_blue, column: rsp_column,
                    row: rsp_row, frame_end: rsp_frame_end};
            if (expected_pixels.size() == 0) begin
               report_fault("unexpected pixel", '0, got);
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) report_fault("pixel mismatch", want, got);
            end
            pixels_seen++;
            if (rsp_frame_end === 1'b1) frames_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && pixels_seen >= 700) begin
            hold_done = 1'b1;
            hold_left = 300;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (pixels_seen >= 100 && pixels_seen < 500) ||
                         $urandom_range(99) >= IDLE_PCT;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d idle cycles at %0t ns", stall_cycles, $time);
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_write(input int addr, input int value);
      pending_reqs.push_back('{kind: KIND_WRITE, address: 15'(addr), data: 8'(value)});
      reqs_queued++;
   endtask

   // Queue a tick with junk in the ignored fields and advance the raster copy
   task automatic push_tick();
      pending_reqs.push_back('{kind: KIND_TICK, address: 15'($urandom),
                               data: 8'($urandom)});
      reqs_queued++;
      gen_col++;
      if (gen_col == LINE_PIXELS) begin
         gen_col  = 0;
         gen_line = (gen_line == VISIBLE_LINES - 1) ? 0 : gen_line + 1;
      end
   endtask

   // Mix of ticks and writes, most writes landing just ahead of the beam
   task automatic push_mixed(input int count);
      int addr;
      repeat (count) begin
         if ($urandom_range(99) < 45) begin
            if ($urandom_range(99) < 65)
               addr = (line_base(gen_line) + gen_col / 8 + $urandom_range(0, 2)) % MEMORY_BYTES;
            else
               addr = $urandom_range(0, MEMORY_BYTES - 1);
            push_write(addr, $urandom_range(0, 255));
         end else begin
            push_tick();
         end
      end
   endtask

   // Wait until every request is taken and every pixel checked, then let the pipe drain
   task automatic settle();
      while (reqs_taken != reqs_queued) @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_scheme(input logic [1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      scheme_sel = value;
      scheme_writes++;
   endtask

   // Stimulus phases
   initial begin
      int sweep_left;
      wait (reset == 1'b0);
      set_scheme(SCHEME_GREEN_ALT);

      // byte patterns at both ends of memory, write right before its read
      push_write(MEMORY_BYTES - 1, 8'hFF);
      push_write(1, 8'h81);
      push_write(0, 8'hA5);
      repeat (16) push_tick();
      push_write(2, 8'h00);
      settle();

      set_scheme(SCHEME_INVERT);
      push_mixed(600);
      settle();
      set_scheme(SCHEME_PALE);
      push_mixed(600);
      settle();
      set_scheme(SCHEME_GREEN);
      push_mixed(600);
      settle();

      // close with a short run of ticks, a few writes just ahead of the beam
      set_scheme(SCHEME_INVERT);
      sweep_left = TAIL_TICKS;
      repeat (sweep_left) begin
         if ($urandom_range(99) < 3)
            push_write((line_base(gen_line) + gen_col / 8 + $urandom_range(1, 3))
                       % MEMORY_BYTES, $urandom_range(0, 255));
         push_tick();
      end
      settle();

      $display("Checked %0d pixels and applied %0d memory writes under %0d scheme settings.",
               pixels_seen, writes_taken, scheme_writes);
      $display("Raster crossed the frame end %0d time(s); %0d mismatch(es) found.",
               frames_done, fault_count);
      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
